@@ rtl/mrms_pkg.sv @@
// Package: shared constants, widths and state type for the RMS meter.
`timescale 1ns / 1ps
`default_nettype none
package mrms_pkg;
    localparam int CHANNELS_DEF = 18;
    localparam int CH_W         = 5;
    localparam int RAW_W        = 12;
    localparam int SUM_W        = 32;
    localparam int SQ_W         = 23;
    localparam int GAIN_W       = 24;
    localparam int WIN_W        = 10;
    localparam int RMS_W        = 16;
    localparam int DVD_W        = 44;
    localparam int DVS_W        = 10;
    localparam int MEAN_W       = 40;
    localparam int ROOT_W       = 20;
    localparam int SREM_W       = 22;
    localparam int STEP_W       = 6;
    localparam int DIV_STEPS    = 44;
    localparam int SQRT_STEPS   = 20;

    // 40960000 = 625 << 16: shift off 16 bits, then multiply by 2^36/625 rounded up
    localparam int SCALE_SH     = 16;
    localparam int QX_W         = 26;
    localparam int RCP_W        = 27;
    localparam int RCP_SH       = 36;
    localparam int QM_W         = 53;

    localparam logic [RAW_W-1:0]  MIDSCALE  = 12'd2048;
    // shifted product at or above 625 * 65536 gives a quotient beyond 16 bits
    localparam logic [QX_W-1:0]   SAT_LIM   = 26'd40960000;
    localparam logic [RCP_W-1:0]  RCP_625   = 27'd109951163;
    localparam logic [GAIN_W-1:0] GAIN_RST  = 24'd256;
    localparam logic [WIN_W-1:0]  WIN_RST   = 10'd100;

    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_WIN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_RD,
        S_LOAD,
        S_DIV1,
        S_SQI,
        S_SQRT,
        S_MUL,
        S_SAT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/mrms_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mrms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/multichannel_rms_meter.sv @@
// Top level: per-channel sum of squares with windowed RMS readout.
//
//  channel  | dir | handshake             | payload
//  s stream | in  | i_s_tvalid/o_s_tready | tdata raw sample, tuser channel, tlast frame end
//  m stream | out | o_m_tvalid/i_m_tready | tdata rms value, tuser channel, tlast window end
//  cfg      | in  | i_cfg_valid/o_cfg_ready | index 0 gain, 1 window
//
// A sample is accepted with a RAM read, then goes to add-and-write-back.
// A closing window emits one item per channel, computed by the 44-step divider
// by the window and the 20-step square root; the scale by 40960000 is a shift
// and a reciprocal multiply.
// Reset clears valid bits and frame count, sets register defaults; the RAM itself is not swept.
// Input stays not ready while a window is being read out; a stalled output holds.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_rms_meter #(
    parameter int CHANNELS = mrms_pkg::CHANNELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [11:0] raw_sample
    input  wire logic [4:0]  i_s_tuser,   // [4:0] channel_index
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,   // [15:0] rms_current
    output logic      [4:0]  o_m_tuser,   // [4:0] out_channel
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mrms_pkg::t_state r_state, n_state;

    logic [mrms_pkg::GAIN_W-1:0] r_gain;
    logic [mrms_pkg::WIN_W-1:0]  r_win_cfg;
    logic [mrms_pkg::WIN_W-1:0]  r_fcnt;
    logic [mrms_pkg::WIN_W-1:0]  win;
    logic [mrms_pkg::WIN_W-1:0]  fcnt_inc;
    logic                        r_fin;
    logic [CHANNELS-1:0]         r_vld;
    logic [AW-1:0]               r_addr;
    logic                        r_inr;
    logic [mrms_pkg::SQ_W-1:0]   r_sq;
    logic [AW-1:0]               r_cidx;
    logic [mrms_pkg::STEP_W-1:0] r_step;
    logic [mrms_pkg::DVD_W-1:0]  r_quo;
    logic [mrms_pkg::DVS_W-1:0]  r_rem;
    logic [mrms_pkg::DVS_W-1:0]  r_dvs;
    logic [mrms_pkg::MEAN_W-1:0] r_sqv;
    logic [mrms_pkg::ROOT_W-1:0] r_root;
    logic [mrms_pkg::SREM_W-1:0] r_srem;
    logic [mrms_pkg::RMS_W-1:0]  r_res;

    logic                        s_acc;
    logic                        m_acc;
    logic [mrms_pkg::RAW_W-1:0]  raw;
    logic [mrms_pkg::RAW_W-1:0]  mag;
    logic                        ch_inr;
    logic [AW-1:0]               raddr;
    logic [mrms_pkg::SUM_W-1:0]  rdata;
    logic [mrms_pkg::SUM_W-1:0]  old_sum;
    logic [mrms_pkg::SUM_W:0]    add_sum;
    logic [mrms_pkg::SUM_W-1:0]  new_sum;
    logic                        we;
    logic                        div_last;
    logic                        sqrt_last;
    logic                        ch_last;
    logic                        win_close;
    logic [mrms_pkg::DVS_W:0]    rem_sh;
    logic [mrms_pkg::DVS_W:0]    rem_sub;
    logic                        rem_ge;
    logic [mrms_pkg::SREM_W+1:0] srem_sh;
    logic [mrms_pkg::SREM_W+1:0] trial;
    logic [mrms_pkg::SREM_W+1:0] srem_sub;
    logic                        srem_ge;
    logic                        qx_sat;
    logic [mrms_pkg::QM_W-1:0]   qmul;

    assign o_cfg_ready = 1'b1;
    assign raw      = i_s_tdata[mrms_pkg::RAW_W-1:0];
    assign mag      = (raw >= mrms_pkg::MIDSCALE) ? raw - mrms_pkg::MIDSCALE
                                                  : mrms_pkg::MIDSCALE - raw;
    assign ch_inr   = 32'(i_s_tuser) < CHANNELS;
    assign win      = (r_win_cfg == '0) ? mrms_pkg::WIN_W'(1) : r_win_cfg;
    assign fcnt_inc = r_fcnt + mrms_pkg::WIN_W'(1);
    assign win_close = i_s_tlast && (fcnt_inc >= win);
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign m_acc    = o_m_tvalid && i_m_tready;
    assign raddr    = (r_state == mrms_pkg::S_IDLE) ? i_s_tuser[AW-1:0] : r_cidx;

    // entries not written since the last window close read as zero
    assign old_sum  = r_vld[r_addr] ? rdata : '0;
    assign add_sum  = {1'b0, old_sum} + (mrms_pkg::SUM_W+1)'(r_sq);
    assign new_sum  = add_sum[mrms_pkg::SUM_W] ? '1 : add_sum[mrms_pkg::SUM_W-1:0];
    assign we       = (r_state == mrms_pkg::S_ACC) && r_inr;

    assign div_last  = 32'(r_step) == mrms_pkg::DIV_STEPS - 1;
    assign sqrt_last = 32'(r_step) == mrms_pkg::SQRT_STEPS - 1;
    assign ch_last   = 32'(r_cidx) == CHANNELS - 1;

    // restoring divider step
    assign rem_sh  = {r_rem, r_quo[mrms_pkg::DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign rem_ge  = rem_sh >= {1'b0, r_dvs};

    // square root digit step
    assign srem_sh  = {r_srem, r_sqv[mrms_pkg::MEAN_W-1 -: 2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign srem_sub = srem_sh - trial;
    assign srem_ge  = srem_sh >= trial;

    // divide by 40960000: drop 16 bits, then divide by 625 via reciprocal
    assign qx_sat = (|r_quo[mrms_pkg::DVD_W-1:mrms_pkg::SCALE_SH+mrms_pkg::QX_W])
                    || (r_quo[mrms_pkg::SCALE_SH +: mrms_pkg::QX_W] >= mrms_pkg::SAT_LIM);
    assign qmul   = mrms_pkg::QM_W'(r_quo[mrms_pkg::SCALE_SH +: mrms_pkg::QX_W])
                    * mrms_pkg::QM_W'(mrms_pkg::RCP_625);

    mrms_ram #(
        .WIDTH (mrms_pkg::SUM_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (new_sum),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrms_pkg::S_IDLE: if (s_acc) n_state = mrms_pkg::S_ACC;
            mrms_pkg::S_ACC:  n_state = r_fin ? mrms_pkg::S_RD : mrms_pkg::S_IDLE;
            mrms_pkg::S_RD:   n_state = mrms_pkg::S_LOAD;
            mrms_pkg::S_LOAD: n_state = mrms_pkg::S_DIV1;
            mrms_pkg::S_DIV1: if (div_last) n_state = mrms_pkg::S_SQI;
            mrms_pkg::S_SQI:  n_state = mrms_pkg::S_SQRT;
            mrms_pkg::S_SQRT: if (sqrt_last) n_state = mrms_pkg::S_MUL;
            mrms_pkg::S_MUL:  n_state = mrms_pkg::S_SAT;
            mrms_pkg::S_SAT:  n_state = mrms_pkg::S_OUT;
            mrms_pkg::S_OUT: begin
                if (m_acc) n_state = ch_last ? mrms_pkg::S_IDLE : mrms_pkg::S_RD;
            end
            default:          n_state = mrms_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = r_state == mrms_pkg::S_IDLE;
        o_m_tvalid = r_state == mrms_pkg::S_OUT;
        o_m_tdata  = r_res;
        o_m_tuser  = mrms_pkg::CH_W'(r_cidx);
        o_m_tlast  = ch_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrms_pkg::S_IDLE;
            r_gain    <= mrms_pkg::GAIN_RST;
            r_win_cfg <= mrms_pkg::WIN_RST;
            r_fcnt    <= '0;
            r_fin     <= 1'b0;
            r_vld     <= '0;
            r_cidx    <= '0;
            r_step    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mrms_pkg::REG_GAIN: r_gain    <= i_cfg_data;
                    mrms_pkg::REG_WIN:  r_win_cfg <= i_cfg_data[mrms_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
            if (we) begin
                r_vld[r_addr] <= 1'b1;
            end
            case (r_state)
                mrms_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_fin  <= win_close;
                        r_cidx <= '0;
                        if (i_s_tlast) begin
                            r_fcnt <= win_close ? '0 : fcnt_inc;
                        end
                    end
                end
                mrms_pkg::S_LOAD, mrms_pkg::S_SQI: r_step <= '0;
                mrms_pkg::S_DIV1, mrms_pkg::S_SQRT: begin
                    r_step <= r_step + mrms_pkg::STEP_W'(1);
                end
                mrms_pkg::S_OUT: begin
                    if (m_acc) begin
                        if (ch_last) begin
                            r_vld <= '0;
                        end else begin
                            r_cidx <= r_cidx + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            mrms_pkg::S_IDLE: begin
                r_addr <= i_s_tuser[AW-1:0];
                r_inr  <= ch_inr;
                r_sq   <= mrms_pkg::SQ_W'({11'b0, mag} * {11'b0, mag});
            end
            mrms_pkg::S_LOAD: begin
                r_quo <= {4'b0, (r_vld[r_cidx] ? rdata : {mrms_pkg::SUM_W{1'b0}}), 8'b0};
                r_rem <= '0;
                r_dvs <= mrms_pkg::DVS_W'(win);
            end
            mrms_pkg::S_DIV1: begin
                r_quo <= {r_quo[mrms_pkg::DVD_W-2:0], rem_ge};
                r_rem <= rem_ge ? rem_sub[mrms_pkg::DVS_W-1:0]
                                : rem_sh[mrms_pkg::DVS_W-1:0];
            end
            mrms_pkg::S_SQI: begin
                r_sqv  <= r_quo[mrms_pkg::MEAN_W-1:0];
                r_root <= '0;
                r_srem <= '0;
            end
            mrms_pkg::S_SQRT: begin
                r_sqv  <= {r_sqv[mrms_pkg::MEAN_W-3:0], 2'b00};
                r_root <= {r_root[mrms_pkg::ROOT_W-2:0], srem_ge};
                r_srem <= srem_ge ? srem_sub[mrms_pkg::SREM_W-1:0]
                                  : srem_sh[mrms_pkg::SREM_W-1:0];
            end
            mrms_pkg::S_MUL: begin
                r_quo <= {24'b0, r_root} * {20'b0, r_gain};
            end
            mrms_pkg::S_SAT: begin
                r_res <= qx_sat ? '1 : qmul[mrms_pkg::RCP_SH +: mrms_pkg::RMS_W];
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/mrms_checker.sv @@
// Checker on the RMS meter ports, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mrms_checker #(
    parameter int CHANNELS = mrms_pkg::CHANNELS_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic [4:0]  o_m_tuser,
    input wire logic        o_m_tlast
);
    // input is never taken while a window is being read out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready during readout");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output item changed while stalled");

    a_last_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (32'(o_m_tuser) == CHANNELS - 1)))
        else $error("tlast not on final channel");

    // after a non-final item the readout goes on
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> !o_s_tready)
        else $error("readout ended early");
endmodule

bind multichannel_rms_meter mrms_checker #(.CHANNELS(CHANNELS)) u_chk (.*);
`default_nettype wire
